@@ rtl/core/sha1sh_pkg.sv @@
// Shared types, constants and command/status structures of the SHA-1 stream hasher.
package sha1sh_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LENGTH_AT   = 56;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned FILL_W      = $clog2(BLOCK_BYTES);
    localparam int unsigned ROUND_W     = $clog2(ROUNDS);
    localparam int unsigned TOTAL_W     = 61;

    localparam logic [FILL_W-1:0]  FILL_LAST  = FILL_W'(BLOCK_BYTES - 1);
    localparam logic [FILL_W-1:0]  FILL_LEN   = FILL_W'(LENGTH_AT);
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    localparam logic [31:0] H_INIT_0 = 32'h67452301;
    localparam logic [31:0] H_INIT_1 = 32'hefcdab89;
    localparam logic [31:0] H_INIT_2 = 32'h98badcfe;
    localparam logic [31:0] H_INIT_3 = 32'h10325476;
    localparam logic [31:0] H_INIT_4 = 32'hc3d2e1f0;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } out_item_t;

    // Source of the byte shifted into the block buffer.
    typedef enum logic [1:0] {
        SEL_INPUT  = 2'd0,
        SEL_MARKER = 2'd1,
        SEL_ZERO   = 2'd2,
        SEL_LENGTH = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic                shift_byte;
        byte_sel_t           byte_sel;
        logic                count_byte;
        logic                load_work;
        logic                round_en;
        logic [ROUND_W-1:0]  round_idx;
        logic                chain_update;
        logic                restart;
        logic                load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
    } dp_status_t;

endpackage

@@ rtl/core/sha1sh_datapath.sv @@
// Datapath of the SHA-1 hasher: block buffer, message schedule, round logic and chaining value.
module sha1sh_datapath #(
    parameter int unsigned TOTAL_W = sha1sh_pkg::TOTAL_W
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             in_byte,
    input  sha1sh_pkg::dp_cmd_t    cmd,
    output sha1sh_pkg::dp_status_t status,
    output sha1sh_pkg::out_item_t  m_data
);

    localparam int unsigned LEN_W = TOTAL_W + 3;

    logic [511:0] buf_reg;
    logic [sha1sh_pkg::FILL_W-1:0] fill_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [31:0] h0_reg, h1_reg, h2_reg, h3_reg, h4_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1sh_pkg::out_item_t out_reg;

    logic [7:0]       byte_next;
    logic [LEN_W-1:0] len_bits;
    logic [63:0]      len_word;
    logic [31:0]      w_top, w_new, f_val, k_val, t_val;

    assign len_bits = {total_reg, 3'b000};
    assign len_word = 64'(len_bits);

    always_comb begin
        case (cmd.byte_sel)
            sha1sh_pkg::SEL_INPUT:  byte_next = in_byte;
            sha1sh_pkg::SEL_MARKER: byte_next = sha1sh_pkg::PAD_MARKER;
            sha1sh_pkg::SEL_LENGTH: byte_next = len_word[{~fill_reg[2:0], 3'b000} +: 8];
            default:                byte_next = 8'h00;
        endcase
    end

    // The buffer doubles as the sixteen-word schedule window; word 0 sits at the top.
    assign w_top = buf_reg[511:480];
    always_comb begin
        logic [31:0] x;
        x = buf_reg[511-32*13 -: 32] ^ buf_reg[511-32*8 -: 32]
          ^ buf_reg[511-32*2 -: 32] ^ buf_reg[511:480];
        w_new = {x[30:0], x[31]};
    end

    always_comb begin
        if (cmd.round_idx < sha1sh_pkg::ROUND_W'(20)) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1sh_pkg::K_0;
        end else if (cmd.round_idx < sha1sh_pkg::ROUND_W'(40)) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K_1;
        end else if (cmd.round_idx < sha1sh_pkg::ROUND_W'(60)) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1sh_pkg::K_2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1sh_pkg::K_3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_top;
    end

    // Control state: fill count, length and chaining value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            total_reg <= '0;
            h0_reg    <= sha1sh_pkg::H_INIT_0;
            h1_reg    <= sha1sh_pkg::H_INIT_1;
            h2_reg    <= sha1sh_pkg::H_INIT_2;
            h3_reg    <= sha1sh_pkg::H_INIT_3;
            h4_reg    <= sha1sh_pkg::H_INIT_4;
        end else begin
            if (cmd.shift_byte) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.restart) begin
                total_reg <= '0;
                h0_reg    <= sha1sh_pkg::H_INIT_0;
                h1_reg    <= sha1sh_pkg::H_INIT_1;
                h2_reg    <= sha1sh_pkg::H_INIT_2;
                h3_reg    <= sha1sh_pkg::H_INIT_3;
                h4_reg    <= sha1sh_pkg::H_INIT_4;
            end else begin
                if (cmd.count_byte) begin
                    total_reg <= total_reg + 1'b1;
                end
                if (cmd.chain_update) begin
                    h0_reg <= h0_reg + a_reg;
                    h1_reg <= h1_reg + b_reg;
                    h2_reg <= h2_reg + c_reg;
                    h3_reg <= h3_reg + d_reg;
                    h4_reg <= h4_reg + e_reg;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.shift_byte) begin
            buf_reg <= {buf_reg[503:0], byte_next};
        end else if (cmd.round_en) begin
            buf_reg <= {buf_reg[479:0], w_new};
        end
        if (cmd.load_work) begin
            a_reg <= h0_reg;
            b_reg <= h1_reg;
            c_reg <= h2_reg;
            d_reg <= h3_reg;
            e_reg <= h4_reg;
        end else if (cmd.round_en) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.load_out) begin
            out_reg.digest_word0 <= h0_reg;
            out_reg.digest_word1 <= h1_reg;
            out_reg.digest_word2 <= h2_reg;
            out_reg.digest_word3 <= h3_reg;
            out_reg.digest_word4 <= h4_reg;
        end
    end

    assign status.fill = fill_reg;
    assign m_data      = out_reg;

endmodule

@@ rtl/core/sha1sh_ctrl.sv @@
// Controller of the SHA-1 hasher: input handshake, padding sequence, rounds and result transfer.
module sha1sh_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   byte_valid,
    input  logic                   end_of_message,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  sha1sh_pkg::dp_status_t status,
    output sha1sh_pkg::dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MARK  = 7'b0000010,
        ST_ZERO  = 7'b0000100,
        ST_LEN   = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_CHAIN = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // Where the sequence resumes once a block has been compressed.
    typedef enum logic [1:0] {
        RET_IDLE = 2'd0,
        RET_MARK = 2'd1,
        RET_ZERO = 2'd2,
        RET_OUT  = 2'd3
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;
    logic [sha1sh_pkg::ROUND_W-1:0] round_reg, round_next;
    logic   m_valid_reg, m_valid_next;
    logic   last_byte;

    assign last_byte = (status.fill == sha1sh_pkg::FILL_LAST);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        round_next = round_reg;
        cmd        = '0;
        cmd.round_idx = round_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (byte_valid) begin
                        cmd.shift_byte = 1'b1;
                        cmd.byte_sel   = sha1sh_pkg::SEL_INPUT;
                        cmd.count_byte = 1'b1;
                    end
                    if (byte_valid && last_byte) begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        ret_next      = end_of_message ? RET_MARK : RET_IDLE;
                        state_next    = ST_ROUND;
                    end else if (end_of_message) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = sha1sh_pkg::SEL_MARKER;
                if (last_byte) begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    ret_next      = RET_ZERO;
                    state_next    = ST_ROUND;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (status.fill == sha1sh_pkg::FILL_LEN) begin
                    state_next = ST_LEN;
                end else begin
                    cmd.shift_byte = 1'b1;
                    cmd.byte_sel   = sha1sh_pkg::SEL_ZERO;
                    if (last_byte) begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        ret_next      = RET_ZERO;
                        state_next    = ST_ROUND;
                    end
                end
            end
            ST_LEN: begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = sha1sh_pkg::SEL_LENGTH;
                if (last_byte) begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    ret_next      = RET_OUT;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 1'b1;
                if (round_reg == sha1sh_pkg::ROUND_LAST) begin
                    state_next = ST_CHAIN;
                end
            end
            ST_CHAIN: begin
                cmd.chain_update = 1'b1;
                case (ret_reg)
                    RET_IDLE: state_next = ST_IDLE;
                    RET_MARK: state_next = ST_MARK;
                    RET_ZERO: state_next = ST_ZERO;
                    default:  state_next = ST_OUT;
                endcase
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    cmd.restart  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= RET_IDLE;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            round_reg   <= round_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ rtl/core/sha1_stream_hasher_core.sv @@
// Top level of the streaming SHA-1 hasher: controller and datapath joined by command and status.
// Throughput: one byte transfer per cycle while a block fills; each full 64-byte block then
// holds the input through 80 rounds of the single round unit and one chaining add.
// Padding: after an end-of-message transfer the controller shifts in the marker, the zero
// bytes and the length, compresses each padded block and then loads the digest into an output
// register, where it waits until it is taken.
// Reset: aresetn is synchronous and active low; it restores the initial hash words, empties the
// buffer count and length and drops the result valid. No clearing pass is needed.
module sha1_stream_hasher_core #(
    parameter int unsigned TOTAL_W = sha1sh_pkg::TOTAL_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha1sh_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha1sh_pkg::out_item_t m_data
);

    // The controller owns the handshakes and sequences padding and rounds; the datapath holds
    // the 512-bit block buffer, which also serves as the sliding message schedule window.
    sha1sh_pkg::dp_cmd_t    dp_cmd;
    sha1sh_pkg::dp_status_t dp_status;

    sha1sh_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .byte_valid     (s_data.byte_valid),
        .end_of_message (s_data.end_of_message),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .status         (dp_status),
        .cmd            (dp_cmd)
    );

    // The datapath takes a new byte only on a transfer, as the controller commands it.
    sha1sh_datapath #(
        .TOTAL_W (TOTAL_W)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (s_data.data_byte),
        .cmd     (dp_cmd),
        .status  (dp_status),
        .m_data  (m_data)
    );

endmodule

@@ rtl/core/sha1sh_checker.sv @@
// Port-level checker of the SHA-1 hasher top level, with its bind statement.
module sha1sh_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input sha1sh_pkg::in_item_t  s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input sha1sh_pkg::out_item_t m_data
);

    // A stalled result stays offered and unchanged.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Reset leaves no result offered.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Ending a message always starts padding, so the input is closed in the following cycle.
    a_end_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.end_of_message |=> !s_ready)
        else $error("input still open after end of message");

    // A fresh digest is only loaded while the input is closed.
    a_digest_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("digest appeared while input was open");

endmodule

bind sha1_stream_hasher_core sha1sh_checker u_sha1sh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ verif/tb_sha1_stream_hasher_core.sv @@
// Self-checking testbench for the streaming SHA-1 hasher, with a digest predictor and scoreboard.

class sha1_digest_scoreboard;

    logic [31:0] chain_words[5];
    logic [7:0]  block_bytes[64];
    int unsigned fill;
    logic [60:0] byte_total;
    sha1sh_pkg::out_item_t expected_digests[$];
    int unsigned mismatches;

    function new();
        restart();
        foreach (block_bytes[i]) block_bytes[i] = '0;
        mismatches = 0;
    endfunction

    function void restart();
        chain_words[0] = sha1sh_pkg::H_INIT_0;
        chain_words[1] = sha1sh_pkg::H_INIT_1;
        chain_words[2] = sha1sh_pkg::H_INIT_2;
        chain_words[3] = sha1sh_pkg::H_INIT_3;
        chain_words[4] = sha1sh_pkg::H_INIT_4;
        fill = 0;
        byte_total = '0;
    endfunction

    function logic [31:0] rotl32(logic [31:0] x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // One 80-round compression of the buffered block into the chaining value.
    function void compress_block();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = sha1sh_pkg::K_0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = sha1sh_pkg::K_1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1sh_pkg::K_2;
            end else begin
                f = b ^ c ^ d;
                k = sha1sh_pkg::K_3;
            end
            t = rotl32(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endfunction

    // Takes one accepted input transfer; an end of message queues the digest it must give.
    function void absorb_transfer(sha1sh_pkg::in_item_t it);
        logic [63:0] bit_len;
        sha1sh_pkg::out_item_t digest;
        if (it.byte_valid) begin
            block_bytes[fill] = it.data_byte;
            fill = (fill + 1) % sha1sh_pkg::BLOCK_BYTES;
            byte_total = byte_total + 1'b1;
            if (fill == 0) compress_block();
        end
        if (!it.end_of_message) return;

        bit_len = {byte_total, 3'b000};
        block_bytes[fill] = sha1sh_pkg::PAD_MARKER;
        fill++;
        // No room left for the length field, so the marker block goes out on its own.
        if (fill > sha1sh_pkg::LENGTH_AT) begin
            for (int i = fill; i < sha1sh_pkg::BLOCK_BYTES; i++) block_bytes[i] = '0;
            compress_block();
            fill = 0;
        end
        for (int i = fill; i < sha1sh_pkg::LENGTH_AT; i++) block_bytes[i] = '0;
        for (int i = 0; i < 8; i++) begin
            block_bytes[sha1sh_pkg::LENGTH_AT + i] = bit_len[63 - 8*i -: 8];
        end
        compress_block();

        digest.digest_word0 = chain_words[0];
        digest.digest_word1 = chain_words[1];
        digest.digest_word2 = chain_words[2];
        digest.digest_word3 = chain_words[3];
        digest.digest_word4 = chain_words[4];
        expected_digests.push_back(digest);
        restart();
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task check_digest(sha1sh_pkg::out_item_t got);
        logic [4:0][31:0] got_words;
        logic [4:0][31:0] want_words;
        if (expected_digests.size() == 0) begin
            report_mismatch($sformatf("digest %h arrived with none expected", got));
            return;
        end
        want_words = expected_digests.pop_front();
        got_words  = got;
        // Word 0 sits in the most significant bits of the packed result.
        for (int i = 0; i < 5; i++) begin
            if (got_words[4-i] !== want_words[4-i]) begin
                report_mismatch($sformatf("digest_word%0d: got %h, expected %h",
                                          i, got_words[4-i], want_words[4-i]));
            end
        end
    endtask

endclass

module tb_sha1_stream_hasher_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned ITEM_TARGET  = 1300;   // byte or end-of-message transfers
    localparam int unsigned PRESSURE_AT  = 400;
    localparam int unsigned CALM_FROM    = 1100;   // no idling on either side from here on
    localparam int unsigned HOLD_CYCLES  = 3000;
    // The worst end-of-message case pads two blocks before the digest is loaded.
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sha1sh_pkg::in_item_t  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sha1sh_pkg::out_item_t m_data;

    sha1_digest_scoreboard digests = new();

    bit          calm          = 1'b0;
    bit          hold_request  = 1'b0;
    bit          pressure_done = 1'b0;
    int unsigned items_sent    = 0;
    int unsigned cycle_count   = 0;

    sha1_stream_hasher_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Both channels are observed at the rising edge, where inputs have been stable since the
    // falling edge. Every accepted input transfer goes to the predictor before any digest
    // that it causes can possibly appear, so the two checks never race each other.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) digests.absorb_transfer(s_data);
        if (aresetn && m_valid && m_ready) digests.check_digest(m_data);
    end

    // Guards against a hang: a correct run finishes in a small fraction of this.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timed out after %0d cycles", $time, cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side. The receiver stalls in short random bursts, and once in the run holds off
    // for a long stretch so that the output register and then the input side back up.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one item and waits for its transfer. Valid stays high across back-to-back items,
    // so a step never sees it both lowered and raised. A random gap may come first.
    task automatic send_item(sha1sh_pkg::in_item_t it);
        if (!calm && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 7)) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.byte_valid || it.end_of_message) items_sent++;
    endtask

    // A whole message of random bytes. The end marker either rides on the last byte or
    // follows as a transfer of its own; idle items are scattered through as noise.
    task automatic send_message(int unsigned len, bit byte_on_last);
        sha1sh_pkg::in_item_t it;
        for (int unsigned n = 0; n < len; n++) begin
            if ($urandom_range(0, 19) == 0) begin
                it.data_byte      = 8'($urandom);
                it.byte_valid     = 1'b0;
                it.end_of_message = 1'b0;
                send_item(it);
            end
            it.data_byte      = 8'($urandom);
            it.byte_valid     = 1'b1;
            it.end_of_message = byte_on_last && (n == len - 1);
            send_item(it);
        end
        if (!byte_on_last || len == 0) begin
            it.data_byte      = 8'($urandom);
            it.byte_valid     = 1'b0;
            it.end_of_message = 1'b1;
            send_item(it);
        end
    endtask

    initial begin : stimulus
        int unsigned len;

        // Synchronous reset, asserted from the start, released once and never asserted again.
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. The empty message first, then an idle item whose data byte is all
        // ones and must be ignored, then a single 0xff byte on the end-of-message item.
        send_message(0, 1'b0);
        send_item(sha1sh_pkg::in_item_t'{8'hff, 1'b0, 1'b0});
        send_item(sha1sh_pkg::in_item_t'{8'hff, 1'b1, 1'b1});
        // The classic three-byte message, with an idle item in the middle of it and the end
        // marker arriving on its own.
        send_item(sha1sh_pkg::in_item_t'{8'h61, 1'b1, 1'b0});
        send_item(sha1sh_pkg::in_item_t'{8'h00, 1'b0, 1'b0});
        send_item(sha1sh_pkg::in_item_t'{8'h62, 1'b1, 1'b0});
        send_item(sha1sh_pkg::in_item_t'{8'h63, 1'b1, 1'b0});
        send_item(sha1sh_pkg::in_item_t'{8'h00, 1'b0, 1'b1});
        // A lone zero byte on the last item, then bytes equal to the padding marker and its
        // complement.
        send_item(sha1sh_pkg::in_item_t'{8'h00, 1'b1, 1'b1});
        send_item(sha1sh_pkg::in_item_t'{8'h80, 1'b1, 1'b0});
        send_item(sha1sh_pkg::in_item_t'{8'h7f, 1'b1, 1'b1});

        // Random messages. Lengths cluster around the points where padding changes shape:
        // just below and above 56 and 120 bytes (one or two padded blocks), the 64-byte boundary and
        // twice it, plus a spread of short messages.
        while (items_sent < ITEM_TARGET) begin
            if (!pressure_done && items_sent >= PRESSURE_AT) begin
                // The receiver holds off while short messages keep coming, so a digest sits
                // unread, the next one backs up behind it and the input stalls.
                hold_request = 1'b1;
                repeat (6) send_message($urandom_range(0, 5), 1'($urandom_range(0, 1)));
                pressure_done = 1'b1;
            end
            calm = (items_sent >= CALM_FROM);
            case ($urandom_range(0, 9))
                0: begin
                    len = $urandom_range(0, 3);
                end
                1: begin
                    len = $urandom_range(54, 57);
                end
                2: begin
                    len = $urandom_range(62, 66);
                end
                3: begin
                    len = $urandom_range(118, 122);
                end
                4: begin
                    len = $urandom_range(127, 129);
                end
                default: begin
                    len = $urandom_range(0, 40);
                end
            endcase
            send_message(len, 1'($urandom_range(0, 1)));
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // Wait for every outstanding digest, then a little longer to catch anything extra.
        while (digests.expected_digests.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (digests.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
